/* sv/assert_macros.svh */
// Assertion macros for the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent must follow it (non-overlapping implication).
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* sv/lsps_pkg.sv */
package lsps_pkg;

  // Default width of the tick count that is actually used.
  localparam int unsigned TIME_BITS_DEF = 24;

  // Shared multiplier geometry.
  localparam int unsigned MUL_A_W = 17;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W   = PROD_W + 1;

  // Configuration register indexes.
  localparam logic [1:0] REG_LOWPASS_COEFF     = 2'd0;
  localparam logic [1:0] REG_LOAD_SCALE        = 2'd1;
  localparam logic [1:0] REG_BLOCKS_PER_SAMPLE = 2'd2;

  // Register values after reset.
  localparam logic [15:0] LOWPASS_COEFF_RST     = 16'd63946;
  localparam logic [15:0] LOAD_SCALE_RST        = 16'd614;
  localparam logic [15:0] BLOCKS_PER_SAMPLE_RST = 16'd93;

  // Q16.16 ceiling of a load, and the half-LSB used for rounding.
  localparam logic [31:0] LOAD_FIX_MAX = 32'hFFFF_0000;
  localparam logic [15:0] RND_HALF     = 16'h8000;
  localparam logic [47:0] SUM_MAX      = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic en;     // update the accumulator this cycle
    logic accum;  // add product and rounding half to it, else load product
  } mac_ctrl_t;

endpackage

/* sv/lsps_mac.sv */
module lsps_mac (
  input  logic                                clk_i,
  input  lsps_pkg::mac_ctrl_t                 ctrl_i,
  input  logic [lsps_pkg::MUL_A_W-1:0]        op_a_i,
  input  logic [lsps_pkg::MUL_B_W-1:0]        op_b_i,
  output logic [lsps_pkg::ACC_W-1:0]          acc_o
);
  import lsps_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  acc_d, acc_q;

  assign prod = PROD_W'(op_a_i) * PROD_W'(op_b_i);

  // Accumulating also adds the half-LSB for the later shift by 16.
  always_comb begin
    if (ctrl_i.accum) begin
      acc_d = acc_q + ACC_W'(prod) + ACC_W'(RND_HALF);
    end else begin
      acc_d = ACC_W'(prod);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

/* sv/load_smoother_with_periodic_stats.sv */
// Load smoother with periodic statistics. Each input word is the processing
// time of one block in timer ticks (only the low TIME_BITS bits count). It is
// scaled to a Q16.16 load percentage by load_scale, saturated at 65535 %,
// smoothed by a one-pole lowpass with Q16 coefficient lowpass_coeff, and the
// smoothed value rounded half up is returned. Every blocks_per_sample blocks
// the rounded value also updates the minimum, maximum, saturating sum and
// saturating sample count, which every result word shows. A word is taken
// in, then a single multiplier is used three times in a row (ticks times
// scale, coefficient times state, complement times load), followed by a
// filter step and a statistics step, which waits while the output register
// cannot take a word. A new word is accepted only in idle, after the last
// one has left the statistics step. The result sits in an output register,
// so the next word may be accepted while the previous result waits to be
// taken. Configuration registers are written through cfg_we_i, cfg_idx_i
// and cfg_data_i; an index beyond the three registers is ignored.
module load_smoother_with_periodic_stats #(
  parameter int unsigned TIME_BITS = lsps_pkg::TIME_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [23:0] elapsed_ticks_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] smoothed_load_o,
  output logic        sample_taken_o,
  output logic [15:0] load_min_o,
  output logic [15:0] load_max_o,
  output logic [47:0] load_sum_o,
  output logic [31:0] sample_count_o
);
  import lsps_pkg::*;

  `include "assert_macros.svh"

  // Sequencer codes.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;  // ticks times scale
  localparam logic [2:0] S_MUL2 = 3'd2;  // coefficient times state, load saturated
  localparam logic [2:0] S_MUL3 = 3'd3;  // add complement times load
  localparam logic [2:0] S_FILT = 3'd4;  // shift and saturate the new state
  localparam logic [2:0] S_STAT = 3'd5;  // round, statistics, result word

  logic [2:0]           state_q, state_d;
  logic [15:0]          coeff_q, scale_q, bps_q;
  logic [TIME_BITS-1:0] ticks_q;
  logic [31:0]          load_q;
  logic [31:0]          smooth_q;
  logic [15:0]          cnt_q;
  logic [15:0]          min_q, max_q;
  logic [47:0]          sum_q;
  logic [31:0]          count_q;

  logic                 out_valid_q, out_valid_d;
  logic [15:0]          out_load_q;
  logic                 out_sample_q;

  mac_ctrl_t            mac_ctrl;
  logic [MUL_A_W-1:0]   mac_a;
  logic [MUL_B_W-1:0]   mac_b;
  logic [ACC_W-1:0]     mac_acc;

  logic                 in_fire;
  logic                 out_free;
  logic [ACC_W-17:0]    filt_shift;
  logic [31:0]          filt_sat;
  logic [31:0]          load_sat;
  logic [32:0]          round_sum;
  logic [15:0]          rounded;
  logic [15:0]          period;
  logic [16:0]          cnt_next;
  logic                 sample;
  logic [48:0]          sum_next;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  // The statistics step may write the output register when it is empty or
  // its word is being taken in this very cycle.
  assign out_free   = !out_valid_q || out_ready_i;

  // The shared multiplier sees different operands in each step.
  always_comb begin
    mac_ctrl = '0;
    mac_a    = '0;
    mac_b    = '0;
    case (state_q)
      S_MUL1: begin
        mac_ctrl.en = 1'b1;
        mac_a       = MUL_A_W'(scale_q);
        mac_b       = MUL_B_W'(ticks_q);
      end
      S_MUL2: begin
        mac_ctrl.en = 1'b1;
        mac_a       = MUL_A_W'(coeff_q);
        mac_b       = smooth_q;
      end
      S_MUL3: begin
        mac_ctrl.en    = 1'b1;
        mac_ctrl.accum = 1'b1;
        mac_a          = (MUL_A_W'(1) << 16) - MUL_A_W'(coeff_q);
        mac_b          = load_q;
      end
      default: begin
        mac_ctrl = '0;
      end
    endcase
  end

  lsps_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .op_a_i (mac_a),
    .op_b_i (mac_b),
    .acc_o  (mac_acc)
  );

  // The scaled load is clamped to 65535.0 % before it enters the filter.
  assign load_sat   = (mac_acc > ACC_W'(LOAD_FIX_MAX)) ? LOAD_FIX_MAX : mac_acc[31:0];

  // The accumulator already holds the rounding half, so the new state is a
  // plain shift, again clamped.
  assign filt_shift = mac_acc[ACC_W-1:16];
  assign filt_sat   = (filt_shift > (ACC_W-16)'(LOAD_FIX_MAX)) ? LOAD_FIX_MAX
                                                              : filt_shift[31:0];

  // Half-up rounding of the Q16.16 state to a whole percentage.
  assign round_sum  = 33'(smooth_q) + 33'(RND_HALF);
  assign rounded    = round_sum[32] ? 16'hFFFF : round_sum[31:16];

  // A period of zero behaves as a sample on every block.
  assign period     = (bps_q == 16'd0) ? 16'd1 : bps_q;
  assign cnt_next   = 17'(cnt_q) + 17'd1;
  assign sample     = (cnt_next >= 17'(period));
  assign sum_next   = 49'(sum_q) + 49'(rounded);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_MUL1;
        end
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_MUL3;
      S_MUL3: state_d = S_FILT;
      S_FILT: state_d = S_STAT;
      S_STAT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == S_STAT) && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state, configuration registers and the filter and statistics state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      coeff_q     <= LOWPASS_COEFF_RST;
      scale_q     <= LOAD_SCALE_RST;
      bps_q       <= BLOCKS_PER_SAMPLE_RST;
      smooth_q    <= '0;
      cnt_q       <= '0;
      min_q       <= '0;
      max_q       <= '0;
      sum_q       <= '0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LOWPASS_COEFF:     coeff_q <= cfg_data_i;
          REG_LOAD_SCALE:        scale_q <= cfg_data_i;
          REG_BLOCKS_PER_SAMPLE: bps_q   <= cfg_data_i;
          default: ;
        endcase
      end

      if (state_q == S_FILT) begin
        smooth_q <= filt_sat;
      end

      if ((state_q == S_STAT) && out_free) begin
        if (sample) begin
          // The first sample sets both extremes.
          if ((count_q == '0) || (rounded < min_q)) begin
            min_q <= rounded;
          end
          if ((count_q == '0) || (rounded > max_q)) begin
            max_q <= rounded;
          end
          sum_q <= sum_next[48] ? SUM_MAX : sum_next[47:0];
          if (count_q != COUNT_MAX) begin
            count_q <= count_q + 32'd1;
          end
          cnt_q <= '0;
        end else begin
          cnt_q <= cnt_next[15:0];
        end
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ticks_q <= TIME_BITS'(elapsed_ticks_i);
    end
    if (state_q == S_MUL2) begin
      load_q <= load_sat;
    end
    if ((state_q == S_STAT) && out_free) begin
      out_load_q   <= rounded;
      out_sample_q <= sample;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign smoothed_load_o = out_load_q;
  assign sample_taken_o  = out_sample_q;
  // The statistics registers only change when a result word is loaded, so
  // they double as the statistics fields of the waiting word.
  assign load_min_o      = min_q;
  assign load_max_o      = max_q;
  assign load_sum_o      = sum_q;
  assign sample_count_o  = count_q;

  // An accepted word starts the multiply sequence at once.
  `ASSERT_NEXT(a_start_seq, clk_i, rst_ni, in_fire, state_q == S_MUL1)
  // A waiting result is never overwritten by the next one.
  `ASSERT_NEXT(a_no_overwrite, clk_i, rst_ni,
    (state_q == S_STAT) && out_valid_q && !out_ready_i, state_q == S_STAT)
  // The filter state never exceeds the load ceiling.
  `ASSERT_ALWAYS(a_state_ceiling, clk_i, rst_ni, smooth_q <= LOAD_FIX_MAX)
  // The block counter is cleared before it can reach the largest period.
  `ASSERT_ALWAYS(a_cnt_range, clk_i, rst_ni, cnt_q != 16'hFFFF)
  // Once a sample exists the extremes are ordered.
  `ASSERT_ALWAYS(a_min_le_max, clk_i, rst_ni, (count_q == '0) || (min_q <= max_q))

endmodule
